FILE: design/assert_macros.svh
// Assertion macros for the orbit camera RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ocp_pkg.sv
// Types, constants and the arctangent table of the orbit camera block.
// No dependencies; used by every module of the block.
package ocp_pkg;

   localparam int DELTA_ANGLE_W = 16;
   localparam int DELTA_DIST_W  = 18;
   localparam int PITCH_W       = 15;
   localparam int DIST_W        = 17;
   localparam int LIMIT_W       = 14;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 17;
   localparam int Q15_W         = 16;
   localparam int CORDIC_W      = 32;
   localparam int MUL_A_W       = 32;
   localparam int MUL_B_W       = 18;
   localparam int PROD_W        = MUL_A_W + MUL_B_W;
   localparam int OFF_W         = 20;
   localparam int ITERS         = 24;
   localparam int ITER_W        = $clog2(ITERS);

   localparam logic [ITER_W-1:0]          LAST_ITER = ITER_W'(ITERS - 1);
   localparam logic signed [CORDIC_W-1:0] CORDIC_K  = 32'sd652032874;

   localparam logic signed [PITCH_W-1:0] PITCH_RESET       = 15'sd3129;
   localparam logic [DIST_W-1:0]         DISTANCE_RESET    = 17'd2560;
   localparam logic [LIMIT_W-1:0]        PITCH_LIMIT_RESET = 14'd14746;
   localparam logic [DIST_W-1:0]         MIN_DIST_RESET    = 17'd256;
   localparam logic [DIST_W-1:0]         MAX_DIST_RESET    = 17'd128000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PITCH_LIMIT  = 2'd0,
      CSR_MIN_DISTANCE = 2'd1,
      CSR_MAX_DISTANCE = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_ROUND,
      ST_MUL_SX,
      ST_MUL_CZ,
      ST_MUL_DX,
      ST_MUL_DZ,
      ST_MUL_DY,
      ST_FIN_Y,
      ST_DONE
   } ocp_state_type;

   typedef enum logic [2:0] {
      MUL_SY_CP,
      MUL_CY_CP,
      MUL_D_SCX,
      MUL_D_SCZ,
      MUL_D_SP
   } mul_sel_type;

   typedef enum logic [1:0] {
      POS_NONE,
      POS_X,
      POS_Y,
      POS_Z
   } pos_sel_type;

   typedef struct packed {
      logic              accept;
      logic              rotate;
      logic [ITER_W-1:0] iter;
      logic              round;
      logic              mul_en;
      mul_sel_type       mul_sel;
      pos_sel_type       pos_sel;
      logic              out_load;
   } ocp_cmd_type;

   // Arctangent of 2^-i, with a quarter turn equal to 2^30.
   function automatic logic signed [CORDIC_W-1:0] atan_angle(input logic [ITER_W-1:0] idx);
      logic signed [CORDIC_W-1:0] a;
      case (idx)
         5'd0:    a = 32'sd536870912;
         5'd1:    a = 32'sd316933405;
         5'd2:    a = 32'sd167458907;
         5'd3:    a = 32'sd85004756;
         5'd4:    a = 32'sd42667331;
         5'd5:    a = 32'sd21354465;
         5'd6:    a = 32'sd10679838;
         5'd7:    a = 32'sd5340245;
         5'd8:    a = 32'sd2670163;
         5'd9:    a = 32'sd1335086;
         5'd10:   a = 32'sd667544;
         5'd11:   a = 32'sd333772;
         5'd12:   a = 32'sd166886;
         5'd13:   a = 32'sd83443;
         5'd14:   a = 32'sd41721;
         5'd15:   a = 32'sd20860;
         5'd16:   a = 32'sd10430;
         5'd17:   a = 32'sd5215;
         5'd18:   a = 32'sd2607;
         5'd19:   a = 32'sd1303;
         5'd20:   a = 32'sd651;
         5'd21:   a = 32'sd325;
         5'd22:   a = 32'sd162;
         5'd23:   a = 32'sd81;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

endpackage

FILE: design/ocp_cordic.sv
// One CORDIC rotation lane: sine and cosine of a 32-bit binary angle in Q1.15.
// Depends on ocp_pkg for widths, the gain constant and the arctangent table.
module ocp_cordic import ocp_pkg::*; (
   input  logic                    clock,
   input  logic                    init,
   input  logic                    step,
   input  logic [ITER_W-1:0]       iter,
   input  logic [CORDIC_W-1:0]     angle,
   output logic signed [Q15_W-1:0] sin_q,
   output logic signed [Q15_W-1:0] cos_q
);

   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic [1:0]                 quad_ff, quad_in;
   logic signed [CORDIC_W-1:0] sh_x, sh_y;
   logic signed [Q15_W-1:0]    cs, sn;

   function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W:0] t;
      logic signed [17:0]       r;
      logic signed [Q15_W-1:0]  q;
      t = (CORDIC_W+1)'(v) + 33'sd16384;
      r = t[CORDIC_W:15];
      if (r > 18'sd32767) begin
         q = 16'sd32767;
      end else if (r < -18'sd32767) begin
         q = -16'sd32767;
      end else begin
         q = r[Q15_W-1:0];
      end
      return q;
   endfunction

   assign sh_x = x_ff >>> iter;
   assign sh_y = y_ff >>> iter;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      if (init) begin
         x_in    = CORDIC_K;
         y_in    = '0;
         z_in    = signed'({2'b00, angle[CORDIC_W-3:0]});
         quad_in = angle[CORDIC_W-1:CORDIC_W-2];
      end else if (step) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - sh_y;
            y_in = y_ff + sh_x;
            z_in = z_ff - atan_angle(iter);
         end else begin
            x_in = x_ff + sh_y;
            y_in = y_ff - sh_x;
            z_in = z_ff + atan_angle(iter);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
   end

   assign cs = to_q15(x_ff);
   assign sn = to_q15(y_ff);

   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_q = cs;
            sin_q = sn;
         end
         2'd1: begin
            cos_q = -sn;
            sin_q = cs;
         end
         2'd2: begin
            cos_q = -cs;
            sin_q = -sn;
         end
         default: begin
            cos_q = sn;
            sin_q = -cs;
         end
      endcase
   end

endmodule

FILE: design/ocp_datapath.sv
// Datapath of the orbit camera: orbit state, settings, two CORDIC lanes,
// a shared multiplier and the saturating position adders. Uses ocp_pkg, ocp_cordic.
module ocp_datapath import ocp_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int COORD_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ocp_cmd_type                    cmd,
   input  logic signed [DELTA_ANGLE_W-1:0] yaw_step,
   input  logic signed [DELTA_ANGLE_W-1:0] pitch_step,
   input  logic signed [DELTA_DIST_W-1:0]  dist_step,
   input  logic signed [COORD_BITS-1:0]    target_x,
   input  logic signed [COORD_BITS-1:0]    target_y,
   input  logic signed [COORD_BITS-1:0]    target_z,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data,
   output logic signed [COORD_BITS-1:0]    pos_x,
   output logic signed [COORD_BITS-1:0]    pos_y,
   output logic signed [COORD_BITS-1:0]    pos_z,
   output logic [ANGLE_BITS-1:0]          yaw_now,
   output logic signed [PITCH_W-1:0]       pitch_now,
   output logic [DIST_W-1:0]              distance_now,
   output logic                           saturated
);

   localparam int ANG_PAD = CORDIC_W - ANGLE_BITS;
   localparam int SUM_W   = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 1;
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] RND_30 = PROD_W'(64'sd536870912);
   localparam logic signed [PROD_W-1:0] RND_15 = PROD_W'(64'sd16384);

   logic [ANGLE_BITS-1:0]        yaw_ff, yaw_in;
   logic signed [PITCH_W-1:0]    pitch_ff, pitch_in;
   logic [DIST_W-1:0]            dist_ff, dist_in;
   logic [LIMIT_W-1:0]           pitch_limit_ff;
   logic [DIST_W-1:0]            min_dist_ff;
   logic [DIST_W-1:0]            max_dist_ff;

   logic signed [COORD_BITS-1:0] tx_ff, ty_ff, tz_ff;
   logic signed [Q15_W-1:0]      sy_ff, cy_ff, sp_ff, cp_ff;
   logic signed [MUL_A_W-1:0]    scx_ff, scz_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [COORD_BITS-1:0] posx_ff, posy_ff, posz_ff;
   logic                         satx_ff, saty_ff, satz_ff;
   logic signed [COORD_BITS-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [ANGLE_BITS-1:0]        out_yaw_ff;
   logic signed [PITCH_W-1:0]    out_pitch_ff;
   logic [DIST_W-1:0]            out_dist_ff;
   logic                         out_sat_ff;

   logic signed [CORDIC_W-1:0]   dy_ext;
   logic signed [PITCH_W+1:0]    p_sum, p_lim, p_clamp;
   logic signed [DIST_W+1:0]     d_sum, d_min, d_max, d_low, d_clamp;
   logic signed [CORDIC_W-1:0]   pitch_ext;
   logic [CORDIC_W-1:0]          yaw_angle, pitch_angle;
   logic signed [Q15_W-1:0]      yaw_sin, yaw_cos, pitch_sin, pitch_cos;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b, dist_op;
   logic signed [PROD_W-1:0]     prod_c, rnd_sum;
   logic signed [OFF_W-1:0]      offset;
   logic signed [COORD_BITS-1:0] tsel;
   logic signed [SUM_W-1:0]      pos_sum;
   logic signed [COORD_BITS-1:0] coord;
   logic                         coord_sat;

   // Orbit state update for the word being accepted.
   always_comb begin
      dy_ext = CORDIC_W'(yaw_step);
      yaw_in = yaw_ff + dy_ext[ANGLE_BITS-1:0];

      p_sum = (PITCH_W+2)'(pitch_ff) + (PITCH_W+2)'(pitch_step);
      p_lim = signed'({3'b000, pitch_limit_ff});
      if (p_sum > p_lim) begin
         p_clamp = p_lim;
      end else if (p_sum < -p_lim) begin
         p_clamp = -p_lim;
      end else begin
         p_clamp = p_sum;
      end
      pitch_in = p_clamp[PITCH_W-1:0];

      d_sum = signed'({2'b00, dist_ff}) + (DIST_W+2)'(dist_step);
      d_min = signed'({2'b00, min_dist_ff});
      d_max = signed'({2'b00, max_dist_ff});
      d_low   = (d_sum < d_min) ? d_min : d_sum;
      d_clamp = (d_low > d_max) ? d_max : d_low;
      dist_in = d_clamp[DIST_W-1:0];

      pitch_ext   = CORDIC_W'(pitch_in);
      yaw_angle   = {yaw_in, {ANG_PAD{1'b0}}};
      pitch_angle = {pitch_ext[ANGLE_BITS-1:0], {ANG_PAD{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff         <= '0;
         pitch_ff       <= PITCH_RESET;
         dist_ff        <= DISTANCE_RESET;
         pitch_limit_ff <= PITCH_LIMIT_RESET;
         min_dist_ff    <= MIN_DIST_RESET;
         max_dist_ff    <= MAX_DIST_RESET;
      end else begin
         if (cmd.accept) begin
            yaw_ff   <= yaw_in;
            pitch_ff <= pitch_in;
            dist_ff  <= dist_in;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_PITCH_LIMIT:  pitch_limit_ff <= csr_data[LIMIT_W-1:0];
               CSR_MIN_DISTANCE: min_dist_ff    <= csr_data[DIST_W-1:0];
               CSR_MAX_DISTANCE: max_dist_ff    <= csr_data[DIST_W-1:0];
               default: ;
            endcase
         end
      end
   end

   ocp_cordic u_yaw_cordic (
      .clock (clock),
      .init  (cmd.accept),
      .step  (cmd.rotate),
      .iter  (cmd.iter),
      .angle (yaw_angle),
      .sin_q (yaw_sin),
      .cos_q (yaw_cos)
   );

   ocp_cordic u_pitch_cordic (
      .clock (clock),
      .init  (cmd.accept),
      .step  (cmd.rotate),
      .iter  (cmd.iter),
      .angle (pitch_angle),
      .sin_q (pitch_sin),
      .cos_q (pitch_cos)
   );

   // Shared multiplier.
   always_comb begin
      dist_op = signed'({1'b0, dist_ff});
      case (cmd.mul_sel)
         MUL_SY_CP: begin
            mul_a = MUL_A_W'(sy_ff);
            mul_b = MUL_B_W'(cp_ff);
         end
         MUL_CY_CP: begin
            mul_a = MUL_A_W'(cy_ff);
            mul_b = MUL_B_W'(cp_ff);
         end
         MUL_D_SCX: begin
            mul_a = scx_ff;
            mul_b = dist_op;
         end
         MUL_D_SCZ: begin
            mul_a = scz_ff;
            mul_b = dist_op;
         end
         MUL_D_SP: begin
            mul_a = MUL_A_W'(sp_ff);
            mul_b = dist_op;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Round the product, add the target and saturate.
   always_comb begin
      case (cmd.pos_sel)
         POS_Y: begin
            rnd_sum = prod_ff + RND_15;
            offset  = rnd_sum[15+OFF_W-1:15];
            tsel    = ty_ff;
         end
         POS_Z: begin
            rnd_sum = prod_ff + RND_30;
            offset  = rnd_sum[30+OFF_W-1:30];
            tsel    = tz_ff;
         end
         default: begin
            rnd_sum = prod_ff + RND_30;
            offset  = rnd_sum[30+OFF_W-1:30];
            tsel    = tx_ff;
         end
      endcase
      pos_sum = SUM_W'(tsel) + SUM_W'(offset);
      if (pos_sum > SAT_HI) begin
         coord     = SAT_HI[COORD_BITS-1:0];
         coord_sat = 1'b1;
      end else if (pos_sum < SAT_LO) begin
         coord     = SAT_LO[COORD_BITS-1:0];
         coord_sat = 1'b1;
      end else begin
         coord     = pos_sum[COORD_BITS-1:0];
         coord_sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tx_ff <= target_x;
         ty_ff <= target_y;
         tz_ff <= target_z;
      end
      if (cmd.round) begin
         sy_ff <= yaw_sin;
         cy_ff <= yaw_cos;
         sp_ff <= pitch_sin;
         cp_ff <= pitch_cos;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_c;
         if (cmd.mul_sel == MUL_CY_CP) begin
            scx_ff <= prod_ff[MUL_A_W-1:0];
         end
         if (cmd.mul_sel == MUL_D_SCX) begin
            scz_ff <= prod_ff[MUL_A_W-1:0];
         end
      end
      case (cmd.pos_sel)
         POS_X: begin
            posx_ff <= coord;
            satx_ff <= coord_sat;
         end
         POS_Y: begin
            posy_ff <= coord;
            saty_ff <= coord_sat;
         end
         POS_Z: begin
            posz_ff <= coord;
            satz_ff <= coord_sat;
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         out_x_ff     <= posx_ff;
         out_y_ff     <= posy_ff;
         out_z_ff     <= posz_ff;
         out_yaw_ff   <= yaw_ff;
         out_pitch_ff <= pitch_ff;
         out_dist_ff  <= dist_ff;
         out_sat_ff   <= satx_ff | saty_ff | satz_ff;
      end
   end

   assign pos_x        = out_x_ff;
   assign pos_y        = out_y_ff;
   assign pos_z        = out_z_ff;
   assign yaw_now      = out_yaw_ff;
   assign pitch_now    = out_pitch_ff;
   assign distance_now = out_dist_ff;
   assign saturated    = out_sat_ff;

endmodule

FILE: design/ocp_ctrl.sv
// Sequencer of the orbit camera: handshakes, CORDIC iteration count and
// multiplier schedule. Uses ocp_pkg for the state and command types.
module ocp_ctrl import ocp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output ocp_cmd_type cmd
);

   ocp_state_type     state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            if (iter_ff == LAST_ITER) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND:  state_in = ST_MUL_SX;
         ST_MUL_SX: state_in = ST_MUL_CZ;
         ST_MUL_CZ: state_in = ST_MUL_DX;
         ST_MUL_DX: state_in = ST_MUL_DZ;
         ST_MUL_DZ: state_in = ST_MUL_DY;
         ST_MUL_DY: state_in = ST_FIN_Y;
         ST_FIN_Y:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.iter     = iter_ff;
      cmd.mul_sel  = MUL_SY_CP;
      cmd.pos_sel  = POS_NONE;
      iter_in      = iter_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            iter_in    = '0;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            iter_in    = iter_ff + ITER_W'(1);
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
         end
         ST_MUL_SX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SY_CP;
         end
         ST_MUL_CZ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CY_CP;
         end
         ST_MUL_DX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_D_SCX;
         end
         ST_MUL_DZ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_D_SCZ;
            cmd.pos_sel = POS_X;
         end
         ST_MUL_DY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_D_SP;
            cmd.pos_sel = POS_Z;
         end
         ST_FIN_Y: begin
            cmd.pos_sel = POS_Y;
         end
         ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/orbit_camera_position.sv
// Orbit camera position: one result word for each request word that is accepted.
// A new request is taken only after the previous one has run the 24-step
// CORDIC rotation loop and the five passes through the shared multiplier.
// A finished result waits in the output register while the next request runs.
// Reset is synchronous and active high; it restores the orbit state and settings.
// Uses ocp_pkg, ocp_ctrl, ocp_datapath and assert_macros.svh.
`include "assert_macros.svh"

module orbit_camera_position import ocp_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int COORD_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // yaw_step, pitch_step, dist_step, target_x, target_y, target_z
   input  logic [((DELTA_ANGLE_W*2+DELTA_DIST_W+3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pos_x, pos_y, pos_z, yaw_now, pitch_now, distance_now
   output logic [((3*COORD_BITS+ANGLE_BITS+PITCH_W+DIST_W+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int DP_LSB = DELTA_ANGLE_W;
   localparam int DD_LSB = 2 * DELTA_ANGLE_W;
   localparam int TX_LSB = DD_LSB + DELTA_DIST_W;
   localparam int TY_LSB = TX_LSB + COORD_BITS;
   localparam int TZ_LSB = TY_LSB + COORD_BITS;
   localparam int RSP_W  = ((3*COORD_BITS+ANGLE_BITS+PITCH_W+DIST_W+7)/8)*8;

   ocp_cmd_type                  cmd;
   logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
   logic [ANGLE_BITS-1:0]        yaw_now;
   logic signed [PITCH_W-1:0]    pitch_now;
   logic [DIST_W-1:0]            distance_now;

   assign csr_ready = 1'b1;

   ocp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ocp_datapath #(
      .ANGLE_BITS (ANGLE_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .yaw_step       (signed'(req_tdata[DP_LSB-1:0])),
      .pitch_step     (signed'(req_tdata[DD_LSB-1:DP_LSB])),
      .dist_step      (signed'(req_tdata[TX_LSB-1:DD_LSB])),
      .target_x       (signed'(req_tdata[TY_LSB-1:TX_LSB])),
      .target_y       (signed'(req_tdata[TZ_LSB-1:TY_LSB])),
      .target_z       (signed'(req_tdata[TZ_LSB+COORD_BITS-1:TZ_LSB])),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pos_x          (pos_x),
      .pos_y          (pos_y),
      .pos_z          (pos_z),
      .yaw_now        (yaw_now),
      .pitch_now      (pitch_now),
      .distance_now   (distance_now),
      .saturated      (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({distance_now, pitch_now, yaw_now, pos_z, pos_y, pos_x});

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready,
      "request accepted while a word is in flight")
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load, !rsp_tvalid || rsp_tready,
      "result register overwritten before it was taken")
   `ASSERT_NEXT(a_valid_after_load, clock, reset, cmd.out_load, rsp_tvalid,
      "loaded result not presented")

endmodule
